// File: hdl/dbtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtd_pkg: shared constants for the three-divisor divisibility core
// Register indexes, reset divisors and lane count used by the core and cells.
// ----------------------------------------------------------------------------
package dbtd_pkg;

    // number of divisor lanes carried through every cell
    localparam int NUM_DIVISORS = 3;

    // configuration register index width
    localparam int CFG_INDEX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIVISOR_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIVISOR_SECOND = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIVISOR_THIRD  = 2'd2;

    // divisor values after reset
    localparam logic [31:0] RESET_DIVISOR_FIRST  = 32'd7;
    localparam logic [31:0] RESET_DIVISOR_SECOND = 32'd73;
    localparam logic [31:0] RESET_DIVISOR_THIRD  = 32'd109;

endpackage

// File: hdl/dbtd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtd_cell: one shift-and-subtract step for all three divisors
// Brings in one dividend bit, does a restoring subtract on each lane's
// partial remainder and hands the result to the next cell.
// ----------------------------------------------------------------------------
module dbtd_cell #(
    parameter int DIVIDEND_BITS = 31,
    parameter int DIVISOR_BITS  = 16,
    parameter int BIT_INDEX     = 30
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                advance,
    input  logic                                                prev_valid,
    input  logic [DIVIDEND_BITS-1:0]                            prev_dividend,
    input  logic [dbtd_pkg::NUM_DIVISORS-1:0][DIVISOR_BITS-1:0] prev_rem,
    input  logic                                                prev_sticky,
    input  logic [dbtd_pkg::NUM_DIVISORS-1:0][DIVISOR_BITS-1:0] divisors,
    output logic                                                valid,
    output logic [DIVIDEND_BITS-1:0]                            dividend,
    output logic [dbtd_pkg::NUM_DIVISORS-1:0][DIVISOR_BITS-1:0] rem,
    output logic                                                sticky
);

    logic                                                valid_reg;
    logic [DIVIDEND_BITS-1:0]                            dividend_reg;
    logic [dbtd_pkg::NUM_DIVISORS-1:0][DIVISOR_BITS-1:0] rem_reg;
    logic [dbtd_pkg::NUM_DIVISORS-1:0][DIVISOR_BITS-1:0] rem_next;
    logic                                                sticky_reg;
    logic                                                sticky_next;
    logic                                                bit_in;

    assign bit_in      = prev_dividend[BIT_INDEX];
    assign sticky_next = prev_sticky | bit_in;

    // restoring step per lane; a zero divisor never subtracts
    always_comb
    begin
        logic [DIVISOR_BITS:0] trial;
        for (int k = 0; k < dbtd_pkg::NUM_DIVISORS; k++)
        begin
            trial = {prev_rem[k], bit_in};
            if ((divisors[k] != '0) && (trial >= {1'b0, divisors[k]}))
            begin
                trial = trial - {1'b0, divisors[k]};
            end
            rem_next[k] = trial[DIVISOR_BITS-1:0];
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dividend_reg <= prev_dividend;
            rem_reg      <= rem_next;
            sticky_reg   <= sticky_next;
        end
    end

    assign valid    = valid_reg;
    assign dividend = dividend_reg;
    assign rem      = rem_reg;
    assign sticky   = sticky_reg;

endmodule

// File: hdl/divisibility_by_three_divisors_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divisibility_by_three_divisors_core: remainder and divisibility flags
// Divides each dividend by three programmable divisors through a chain of
// restoring-division cells and reports the remainders and zero flags.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  in       | in_valid / in_ready   | dividend
//  out      | out_valid / out_ready | remainder_*, divisible_*
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (write only)
//
// one cell per dividend bit: a transaction passes through every cell of the
// chain and then the output register, and a new one may enter every cycle
// the whole chain moves together; it holds only while its last cell is full
// and the output register holds a transaction not yet taken
// reset empties the chain and loads divisors 7, 73 and 109
// cfg_ready is always high; writes to unknown indexes are dropped
// ----------------------------------------------------------------------------
module divisibility_by_three_divisors_core #(
    parameter int DIVIDEND_BITS = 31,
    parameter int DIVISOR_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input transaction
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [DIVIDEND_BITS-1:0]            dividend,
    // result transaction
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [DIVISOR_BITS-1:0]             remainder_first,
    output logic [DIVISOR_BITS-1:0]             remainder_second,
    output logic [DIVISOR_BITS-1:0]             remainder_third,
    output logic                                divisible_first,
    output logic                                divisible_second,
    output logic                                divisible_third,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dbtd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DIVISOR_BITS-1:0]             cfg_data
);

    localparam int NL = dbtd_pkg::NUM_DIVISORS;

    logic [NL-1:0][DIVISOR_BITS-1:0] divisor_reg;

    logic                            stage_valid    [0:DIVIDEND_BITS];
    logic [DIVIDEND_BITS-1:0]        stage_dividend [0:DIVIDEND_BITS];
    logic [NL-1:0][DIVISOR_BITS-1:0] stage_rem      [0:DIVIDEND_BITS];
    logic                            stage_sticky   [0:DIVIDEND_BITS];

    logic                            advance;
    logic                            out_load;
    logic                            out_valid_reg;
    logic [NL-1:0][DIVISOR_BITS-1:0] out_rem_reg;
    logic [NL-1:0]                   out_flag_reg;
    logic [NL-1:0]                   flag_next;

    // divisor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg[0] <= DIVISOR_BITS'(dbtd_pkg::RESET_DIVISOR_FIRST);
            divisor_reg[1] <= DIVISOR_BITS'(dbtd_pkg::RESET_DIVISOR_SECOND);
            divisor_reg[2] <= DIVISOR_BITS'(dbtd_pkg::RESET_DIVISOR_THIRD);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dbtd_pkg::REG_DIVISOR_FIRST:  divisor_reg[0] <= cfg_data;
                dbtd_pkg::REG_DIVISOR_SECOND: divisor_reg[1] <= cfg_data;
                dbtd_pkg::REG_DIVISOR_THIRD:  divisor_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // chain moves unless its last cell is blocked by a full output register
    assign advance  = !stage_valid[DIVIDEND_BITS] || !out_valid_reg || out_ready;
    assign in_ready = advance;

    // chain entry
    assign stage_valid[0]    = in_valid;
    assign stage_dividend[0] = dividend;
    assign stage_rem[0]      = '0;
    assign stage_sticky[0]   = 1'b0;

    // one cell per dividend bit, most significant first
    for (genvar i = 0; i < DIVIDEND_BITS; i++)
    begin : g_cell
        dbtd_cell #(
            .DIVIDEND_BITS (DIVIDEND_BITS),
            .DIVISOR_BITS  (DIVISOR_BITS),
            .BIT_INDEX     (DIVIDEND_BITS - 1 - i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .prev_valid    (stage_valid[i]),
            .prev_dividend (stage_dividend[i]),
            .prev_rem      (stage_rem[i]),
            .prev_sticky   (stage_sticky[i]),
            .divisors      (divisor_reg),
            .valid         (stage_valid[i+1]),
            .dividend      (stage_dividend[i+1]),
            .rem           (stage_rem[i+1]),
            .sticky        (stage_sticky[i+1])
        );
    end

    // zero flag; zero divisor: remainder is dividend's low DIVISOR_BITS bits
    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            flag_next[k] = (stage_rem[DIVIDEND_BITS][k] == '0) &&
                           !((divisor_reg[k] == '0) && stage_sticky[DIVIDEND_BITS]);
        end
    end

    assign out_load = stage_valid[DIVIDEND_BITS] && (!out_valid_reg || out_ready);

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rem_reg  <= stage_rem[DIVIDEND_BITS];
            out_flag_reg <= flag_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign remainder_first  = out_rem_reg[0];
    assign remainder_second = out_rem_reg[1];
    assign remainder_third  = out_rem_reg[2];
    assign divisible_first  = out_flag_reg[0];
    assign divisible_second = out_flag_reg[1];
    assign divisible_third  = out_flag_reg[2];

endmodule
